### rtl/core/lqpr_pkg.sv
// Shared types, constants and helpers for the lane queue block.
`default_nettype none
package lqpr_pkg;

    localparam int LANE_COUNT   = 4;
    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int LANE_W  = 2;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = 5;
    localparam int ADDR_W  = $clog2(LANE_COUNT * QUEUE_DEPTH);
    localparam int GRANT_W = 4;
    localparam int GREEN_W = $clog2(LANE_COUNT);
    localparam int MARK_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] MODE_ENQ  = 2'd0;
    localparam logic [1:0] MODE_DEQ  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 1'd1;

    localparam logic [MARK_W-1:0] HIGH_MARK_RESET = 5'd10;
    localparam logic [MARK_W-1:0] LOW_MARK_RESET  = 5'd5;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_TICK,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [LANE_W-1:0]       lane_select;
        logic [PAYLOAD_BITS-1:0] payload_in;
    } in_item_t;

    typedef struct packed {
        logic                    op_ok;
        logic [PAYLOAD_BITS-1:0] payload_out;
        logic [FILL_W-1:0]       lane_fill;
        logic [GRANT_W-1:0]      grant_onehot;
        logic                    priority_on;
    } out_item_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [LANE_W-1:0]       lane;
        logic                    lane_ok;
        logic [PAYLOAD_BITS-1:0] payload;
    } op_t;

    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] ptr);
        if (ptr == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + PTR_W'(1);
    endfunction

endpackage
`default_nettype wire

### rtl/core/lqpr_front.sv
// Front end: accept and classify items, buffer them in a short queue.
`default_nettype none
module lqpr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lqpr_pkg::in_item_t cmd,
    output logic                   busy,
    output logic                   op_valid,
    output lqpr_pkg::op_t          op
);

    lqpr_pkg::op_t q_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;
    lqpr_pkg::op_t new_op;

    always_comb
    begin
        new_op.lane    = cmd.lane_select;
        new_op.payload = cmd.payload_in;
        new_op.lane_ok = ({1'b0, cmd.lane_select} < (lqpr_pkg::LANE_W + 1)'(lqpr_pkg::LANE_COUNT));
        unique case (cmd.mode)
            lqpr_pkg::MODE_ENQ:  new_op.kind = lqpr_pkg::OP_ENQ;
            lqpr_pkg::MODE_DEQ:  new_op.kind = lqpr_pkg::OP_DEQ;
            lqpr_pkg::MODE_TICK: new_op.kind = lqpr_pkg::OP_TICK;
            default:             new_op.kind = lqpr_pkg::OP_NOP;
        endcase
    end

    assign busy     = (count_reg == 2'd2);
    assign push     = start && !busy;
    assign op_valid = (count_reg != 2'd0);
    assign pop      = op_valid;
    assign op       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_op;
        end
    end

endmodule
`default_nettype wire

### rtl/core/lqpr_back.sv
// Back end: lane FIFOs, payload memory and the priority grant rotation.
`default_nettype none
module lqpr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          op_valid,
    input  wire lqpr_pkg::op_t                 op,
    input  wire logic [lqpr_pkg::MARK_W-1:0]   high_mark,
    input  wire logic [lqpr_pkg::MARK_W-1:0]   low_mark,
    output logic                               result_valid,
    output lqpr_pkg::out_item_t                result
);

    localparam int PTR_W   = lqpr_pkg::PTR_W;
    localparam int FILL_W  = lqpr_pkg::FILL_W;
    localparam int ADDR_W  = lqpr_pkg::ADDR_W;
    localparam int GREEN_W = lqpr_pkg::GREEN_W;
    localparam int GRANT_W = lqpr_pkg::GRANT_W;
    localparam int PW      = lqpr_pkg::PAYLOAD_BITS;
    localparam int LANES   = lqpr_pkg::LANE_COUNT;

    logic [PW-1:0]      mem [LANES * lqpr_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0]   head_reg [LANES];
    logic [PTR_W-1:0]   head_next [LANES];
    logic [PTR_W-1:0]   tail_reg [LANES];
    logic [PTR_W-1:0]   tail_next [LANES];
    logic [FILL_W-1:0]  fill_reg [LANES];
    logic [FILL_W-1:0]  fill_next [LANES];
    logic               prio_reg;
    logic               prio_next;
    logic [GREEN_W-1:0] green_reg;
    logic [GREEN_W-1:0] green_next;
    logic [GRANT_W-1:0] lights_reg;
    logic [GRANT_W-1:0] lights_next;

    logic               valid_reg;
    logic               ok_reg;
    logic               deq_reg;
    logic [FILL_W-1:0]  lane_fill_reg;
    logic [PW-1:0]      rdata_reg;

    logic [FILL_W-1:0]  fill_cur;
    logic [PTR_W-1:0]   tail_inc;
    logic               enq_ok;
    logic               deq_ok;
    logic [ADDR_W-1:0]  lane_base;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [FILL_W-1:0]  fill0;
    logic               prio_keep;
    logic [GREEN_W-1:0] green_inc;
    logic [FILL_W-1:0]  res_fill;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        prio_next   = prio_reg;
        green_next  = green_reg;
        lights_next = lights_reg;
        prio_keep   = prio_reg;

        fill_cur  = fill_reg[op.lane];
        tail_inc  = lqpr_pkg::ptr_wrap(tail_reg[op.lane]);
        enq_ok    = op_valid && (op.kind == lqpr_pkg::OP_ENQ) && op.lane_ok
                    && (fill_cur < FILL_W'(lqpr_pkg::QUEUE_DEPTH));
        deq_ok    = op_valid && (op.kind == lqpr_pkg::OP_DEQ) && op.lane_ok
                    && (fill_cur != '0);
        lane_base = ADDR_W'(ADDR_W'(op.lane) * ADDR_W'(lqpr_pkg::QUEUE_DEPTH));
        waddr     = lane_base + ADDR_W'(tail_inc);
        raddr     = lane_base + ADDR_W'(head_reg[op.lane]);

        if (enq_ok)
        begin
            tail_next[op.lane] = tail_inc;
            fill_next[op.lane] = fill_cur + FILL_W'(1);
        end
        if (deq_ok)
        begin
            head_next[op.lane] = lqpr_pkg::ptr_wrap(head_reg[op.lane]);
            fill_next[op.lane] = fill_cur - FILL_W'(1);
        end

        fill0     = fill_reg[0];
        green_inc = (green_reg == GREEN_W'(LANES - 1)) ? '0 : green_reg + GREEN_W'(1);
        if (op_valid && (op.kind == lqpr_pkg::OP_TICK))
        begin
            if ((fill0 > high_mark) && !prio_reg)
            begin
                prio_next   = 1'b1;
                green_next  = '0;
                lights_next = GRANT_W'(1);
            end
            else
            begin
                prio_keep = prio_reg && !(fill0 < low_mark);
                prio_next = prio_keep;
                if (!prio_keep)
                begin
                    green_next  = green_inc;
                    lights_next = GRANT_W'(1) << green_inc;
                end
            end
        end

        res_fill = op.lane_ok ? fill_next[op.lane] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= PTR_W'(lqpr_pkg::QUEUE_DEPTH - 1);
                fill_reg[i] <= '0;
            end
            prio_reg   <= 1'b0;
            green_reg  <= '0;
            lights_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            prio_reg   <= prio_next;
            green_reg  <= green_next;
            lights_reg <= lights_next;
            valid_reg  <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg        <= enq_ok || deq_ok;
        deq_reg       <= deq_ok;
        lane_fill_reg <= res_fill;
    end

    always_ff @(posedge clk)
    begin
        if (enq_ok)
        begin
            mem[waddr] <= op.payload;
        end
        rdata_reg <= mem[raddr];
    end

    assign result_valid        = valid_reg;
    assign result.op_ok        = ok_reg;
    assign result.payload_out  = deq_reg ? rdata_reg : '0;
    assign result.lane_fill    = lane_fill_reg;
    assign result.grant_onehot = lights_reg;
    assign result.priority_on  = prio_reg;

endmodule
`default_nettype wire

### rtl/core/lane_queues_priority_rotation.sv
// Top level: lane queues with round-robin grant and lane 0 priority override.
//
//  channel   handshake             payload
//  -------   --------------------  -----------------------------------
//  command   start / busy          cmd (mode, lane_select, payload_in)
//  result    result_valid strobe   result (op_ok .. priority_on)
//  config    cfg_we                cfg_index, cfg_data
//
// One item per cycle sustained; the result strobe rises once the item has passed
// the front queue register and the back end result register.
// The item is held in the front queue; the back end registers the result and
// the memory read in the cycle the item leaves the queue head.
// Busy stays low: the back end drains the two-entry queue every cycle.
// Reset empties all lanes, clears grant and priority, and loads marks 10 and 5.
// The receiver cannot stall: each result strobe lasts one cycle.
`default_nettype none
module lane_queues_priority_rotation (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire lqpr_pkg::in_item_t               cmd,
    output logic                                  busy,
    output logic                                  result_valid,
    output lqpr_pkg::out_item_t                   result,
    input  wire logic                             cfg_we,
    input  wire logic [lqpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lqpr_pkg::MARK_W-1:0]      cfg_data
);

    logic [lqpr_pkg::MARK_W-1:0] high_mark_reg;
    logic [lqpr_pkg::MARK_W-1:0] low_mark_reg;
    logic                        op_valid;
    lqpr_pkg::op_t               op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_mark_reg <= lqpr_pkg::HIGH_MARK_RESET;
            low_mark_reg  <= lqpr_pkg::LOW_MARK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lqpr_pkg::CFG_HIGH_MARK: high_mark_reg <= cfg_data;
                lqpr_pkg::CFG_LOW_MARK:  low_mark_reg  <= cfg_data;
                default:                 high_mark_reg <= high_mark_reg;
            endcase
        end
    end

    lqpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .op_valid (op_valid),
        .op       (op)
    );

    lqpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op           (op),
        .high_mark    (high_mark_reg),
        .low_mark     (low_mark_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire
